>>> hdl/gpq_pkg.sv
package gpq_pkg;

	localparam int MAX_PENS  = 256;
	localparam int PEN_AW    = (MAX_PENS > 1) ? $clog2(MAX_PENS) : 1;
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;
	localparam int PEN_W     = 8;
	localparam int CNT_W     = 9;
	localparam int GREY_W    = 11;
	localparam int ERR_W     = 12;
	localparam int SUM_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [GREY_W-1:0] GREY_TOP  = GREY_W'(7 * 256 - 1);
	localparam logic [GREY_W-1:0] DIST_INIT = GREY_W'(7 * 256);

	// input item kinds
	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_PEN   = 2'd1;
	localparam logic [1:0] MODE_REG   = 2'd2;
	localparam logic [1:0] MODE_PAL   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DITHER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PENS   = 2'd2;

	typedef struct packed {
		logic wr_pen;
		logic wr_reg;
		logic wr_pal;
		logic capture;
		logic tgt_load;
		logic issue;
		logic out_load;
	} gpq_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic pipe_busy;
		logic out_free;
	} gpq_sts_t;

endpackage

>>> hdl/gpq_ram.sv
module gpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/gpq_ctrl.sv
module gpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       mode,
	input  gpq_pkg::gpq_sts_t sts,
	output gpq_pkg::gpq_cmd_t cmd
);
	import gpq_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAL   = 3'd1;
	localparam logic [2:0] ST_TGT   = 3'd2;
	localparam logic [2:0] ST_SRCH  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.wr_pen   = accept && (mode == MODE_PEN);
		cmd.wr_reg   = accept && (mode == MODE_REG);
		cmd.wr_pal   = accept && (mode == MODE_PAL);
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_PIXEL)) begin
					cmd.capture = 1'b1;
					state_d     = ST_PAL;
				end
			end
			ST_PAL: begin
				// palette read in flight
				state_d = ST_TGT;
			end
			ST_TGT: begin
				cmd.tgt_load = 1'b1;
				state_d      = ST_SRCH;
			end
			ST_SRCH: begin
				cmd.issue = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/gpq_dp.sv
module gpq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gpq_pkg::gpq_cmd_t                 cmd,
	output gpq_pkg::gpq_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic [gpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              frame_start,
	input  logic [7:0]                        red,
	input  logic [7:0]                        green,
	input  logic [7:0]                        blue,
	input  logic [7:0]                        slot,
	input  logic [7:0]                        pen_number,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        pen_out
);
	import gpq_pkg::*;

	logic                     dither_q;
	logic                     cmode_q;
	logic [CNT_W-1:0]         pens_q;

	logic [GREY_W-1:0]        in_grey;
	logic [GREY_W-1:0]        grey_q;
	logic [TBL_AW-1:0]        slot_q;
	logic                     fs_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_q;
	logic [GREY_W-1:0]        target_q;
	logic [GREY_W-1:0]        clamped;

	logic [PEN_AW-1:0]        idx_q;
	logic [PEN_AW-1:0]        last_idx;
	logic                     v_s1;
	logic                     v_s2;
	logic [PEN_W-1:0]         pen_s2;
	logic [PEN_W-1:0]         pen_rdata;
	logic [GREY_W-1:0]        reg_rdata;
	logic [GREY_W-1:0]        pal_rdata;
	logic [GREY_W-1:0]        cur_gap;
	logic [GREY_W-1:0]        best_dist_q;
	logic [PEN_W-1:0]         best_pen_q;
	logic [GREY_W-1:0]        best_grey_q;

	logic signed [SUM_W-1:0]  diff;
	logic signed [SUM_W-1:0]  half;
	logic                     pen_slot_ok;

	assign in_grey = {2'b00, red, 1'b0} + {1'b0, green, 2'b00} + {3'b000, blue};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_q <= 1'b0;
			cmode_q  <= 1'b0;
			pens_q   <= CNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DITHER: dither_q <= cfg_data[0];
				CFG_CMODE:  cmode_q  <= cfg_data[0];
				CFG_PENS:   pens_q   <= cfg_data[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// zero pens counts as one, large counts saturate
	always_comb begin
		if (pens_q == '0) begin
			last_idx = '0;
		end else if (pens_q > CNT_W'(MAX_PENS)) begin
			last_idx = PEN_AW'(MAX_PENS - 1);
		end else begin
			last_idx = PEN_AW'(pens_q - CNT_W'(1));
		end
	end

	assign pen_slot_ok = ({1'b0, slot} < CNT_W'(MAX_PENS));

	gpq_ram #(.WIDTH(PEN_W), .DEPTH(MAX_PENS)) u_pen_list (
		.clk   (clk),
		.we    (cmd.wr_pen && pen_slot_ok),
		.waddr (slot[PEN_AW-1:0]),
		.wdata (pen_number),
		.raddr (idx_q),
		.rdata (pen_rdata)
	);

	gpq_ram #(.WIDTH(GREY_W), .DEPTH(TBL_DEPTH)) u_reg_grey (
		.clk   (clk),
		.we    (cmd.wr_reg),
		.waddr (slot),
		.wdata (in_grey),
		.raddr (pen_rdata),
		.rdata (reg_rdata)
	);

	gpq_ram #(.WIDTH(GREY_W), .DEPTH(TBL_DEPTH)) u_pal_grey (
		.clk   (clk),
		.we    (cmd.wr_pal),
		.waddr (slot),
		.wdata (in_grey),
		.raddr (slot_q),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			grey_q <= in_grey;
			slot_q <= slot;
			fs_q   <= frame_start;
		end
	end

	// target: palette grey in cmode; else pixel grey, plus carried error (dropped at frame start) when dithering
	assign sum = $signed({2'b00, grey_q})
		+ (fs_q ? SUM_W'(0) : SUM_W'(err_q));

	always_comb begin
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > $signed({2'b00, GREY_TOP})) begin
			clamped = GREY_TOP;
		end else begin
			clamped = sum[GREY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_load) begin
			sum_q <= sum;
			if (cmode_q) begin
				target_q <= pal_rdata;
			end else if (dither_q) begin
				target_q <= clamped;
			end else begin
				target_q <= grey_q;
			end
		end
	end

	// search pipeline: pen list read, then register grey read, then compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.tgt_load) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + PEN_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		pen_s2 <= pen_rdata;
	end

	assign cur_gap = (reg_rdata >= target_q) ? (reg_rdata - target_q) : (target_q - reg_rdata);

	always_ff @(posedge clk) begin
		if (cmd.tgt_load) begin
			best_dist_q <= DIST_INIT;
		end else if (v_s2 && (cur_gap < best_dist_q)) begin
			best_dist_q <= cur_gap;
			best_pen_q  <= pen_s2;
			best_grey_q <= reg_rdata;
		end
	end

	// half the error, truncated toward zero
	assign diff = sum_q - $signed({2'b00, best_grey_q});
	assign half = (diff + (diff[SUM_W-1] ? SUM_W'(1) : SUM_W'(0))) >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
		end else if (cmd.tgt_load && fs_q) begin
			err_q <= '0;
		end else if (cmd.out_load && !cmode_q && dither_q) begin
			err_q <= half[ERR_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pen_out <= best_pen_q;
		end
	end

	assign sts.cnt_last  = (idx_q == last_idx);
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !out_valid || !out_stall;

endmodule

>>> hdl/grey_pen_quantizer_dither.sv
// load items give no result; the block stays idle and is ready again next cycle
// a pixel is captured, its palette grey read and its target loaded; then the pen search
// reads one pen list entry per cycle (1..256 pens) through a two-read pipeline, drains,
// loads the result once the output is free, and takes the next item the cycle after that
// reset clears config (no dither, rgb, two pens) and carried error; tables are unset
module grey_pen_quantizer_dither (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic                          frame_start,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    slot,
	input  logic [7:0]                    pen_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    pen_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import gpq_pkg::*;

	gpq_cmd_t cmd;
	gpq_sts_t sts;

	assign cfg_ready = 1'b1;

	gpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	gpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.frame_start (frame_start),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.slot        (slot),
		.pen_number  (pen_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pen_out     (pen_out)
	);

endmodule
